// ===== src/cisv_pkg.sv =====
// Shared types and constants for the CBOR item skip validator.
`default_nettype none
package cisv_pkg;

	localparam int MAX_NEST_DEF = 32;

	// result codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_RSVD  = 2'd2;
	localparam logic [1:0] ST_DEEP  = 2'd3;

	// major types that matter here
	localparam logic [2:0] MAJ_BSTR  = 3'd2;
	localparam logic [2:0] MAJ_TSTR  = 3'd3;
	localparam logic [2:0] MAJ_ARRAY = 3'd4;
	localparam logic [2:0] MAJ_MAP   = 3'd5;
	localparam logic [2:0] MAJ_TAG   = 3'd6;

	// additional info bounds: 24..27 carry 1, 2, 4 or 8 argument bytes
	localparam logic [4:0] INFO_ARG1 = 5'd24;
	localparam logic [4:0] INFO_ARG8 = 5'd27;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROC,
		S_POP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic cap;   // latch the incoming byte
		logic proc;  // decode the latched byte
		logic pop;   // close one more nesting level
		logic emit;  // verdict waits for the output register
		logic fin;   // byte done: offsets advance, result loads
	} cmd_t;

	typedef struct packed {
		logic need_pop;
		logic vld;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/cisv_ctrl.sv =====
// Controller state machine for the CBOR item skip validator.
`default_nettype none
module cisv_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             byte_valid,
	output logic            byte_stall,
	input  cisv_pkg::stat_t stat,
	output cisv_pkg::cmd_t  cmd
);

	cisv_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cisv_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cisv_pkg::S_IDLE: begin
				if (byte_valid) state_d = cisv_pkg::S_PROC;
			end
			cisv_pkg::S_PROC, cisv_pkg::S_POP: begin
				if (stat.need_pop) state_d = cisv_pkg::S_POP;
				else if (!stat.vld || stat.out_free) state_d = cisv_pkg::S_IDLE;
				else state_d = cisv_pkg::S_EMIT;
			end
			cisv_pkg::S_EMIT: begin
				if (stat.out_free) state_d = cisv_pkg::S_IDLE;
			end
			default: state_d = cisv_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		byte_stall = 1'b1;
		case (state_q)
			cisv_pkg::S_IDLE: begin
				byte_stall = 1'b0;
				cmd.cap    = byte_valid;
			end
			cisv_pkg::S_PROC: begin
				cmd.proc = 1'b1;
				cmd.fin  = !stat.need_pop && (!stat.vld || stat.out_free);
			end
			cisv_pkg::S_POP: begin
				cmd.pop = 1'b1;
				cmd.fin = !stat.need_pop && (!stat.vld || stat.out_free);
			end
			cisv_pkg::S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.fin  = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/cisv_dp.sv =====
// Datapath: head decode, payload skip, child-count stack and result register.
`default_nettype none
module cisv_dp #(
	parameter int MAX_NEST = cisv_pkg::MAX_NEST_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  cisv_pkg::cmd_t  cmd,
	output cisv_pkg::stat_t stat,
	input  wire [7:0]       in_byte,
	input  wire             last_byte,
	output logic            result_valid,
	input  wire             result_stall,
	output logic [1:0]      status,
	output logic [63:0]     item_start,
	output logic [63:0]     item_length
);

	localparam int NW        = $clog2(MAX_NEST + 1);
	localparam int AW        = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
	localparam int MEM_DEPTH = 1 << AW;

	// latched transaction
	logic [7:0]    byte_q;
	logic          last_q;

	// parse state; top_q caches the innermost child count, mem holds the rest
	logic          err_q;
	logic [3:0]    argdue_q, argdue_d;
	logic [63:0]   arg_q, arg_d;
	logic [2:0]    pmaj_q, pmaj_d;
	logic [63:0]   pay_q, pay_d;
	logic [NW-1:0] nest_q, nest_d;
	logic [63:0]   top_q, top_d;
	logic [63:0]   off_q;
	logic [63:0]   start_q, start_d;
	logic          vval_q;
	logic [1:0]    vcode_q;

	logic [63:0]   mem [MEM_DEPTH];
	logic [63:0]   rd_q;
	logic [AW-1:0] raddr, waddr;
	logic          push_we;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [63:0]   ostart_q;
	logic [63:0]   olen_q;

	logic [2:0]    major;
	logic [4:0]    info;
	logic          hd, idone, rsvd, deep, done0, need_pop, is_cont;
	logic [2:0]    hmaj;
	logic [63:0]   hval, cnt;
	logic          vld;
	logic [1:0]    code;
	logic [63:0]   start_use;
	logic          out_free;
	logic          buf_end;

	assign major = byte_q[7:5];
	assign info  = byte_q[4:0];
	// the entry just under the top; each pop cycle this lines up with the next level
	assign raddr = AW'(nest_q - NW'(2));
	assign waddr = AW'(nest_q - NW'(1));

	always_comb begin
		argdue_d = argdue_q;
		arg_d    = arg_q;
		pmaj_d   = pmaj_q;
		pay_d    = pay_q;
		nest_d   = nest_q;
		top_d    = top_q;
		start_d  = start_q;
		push_we  = 1'b0;
		hd       = 1'b0;
		hmaj     = major;
		hval     = 64'(info);
		idone    = 1'b0;
		rsvd     = 1'b0;
		deep     = 1'b0;
		done0    = 1'b0;
		need_pop = 1'b0;
		is_cont  = 1'b0;
		cnt      = '0;
		if (cmd.proc && !err_q) begin
			if (argdue_q != 4'd0) begin
				arg_d    = {arg_q[55:0], byte_q};
				argdue_d = argdue_q - 4'd1;
				hd       = (argdue_q == 4'd1);
				hmaj     = pmaj_q;
				hval     = {arg_q[55:0], byte_q};
			end else if (pay_q != 64'd0) begin
				pay_d = pay_q - 64'd1;
				idone = (pay_q == 64'd1);
			end else begin
				if (nest_q == '0) start_d = off_q;
				if (info < cisv_pkg::INFO_ARG1) begin
					hd = 1'b1;
				end else if (info > cisv_pkg::INFO_ARG8) begin
					rsvd = 1'b1;
				end else begin
					pmaj_d   = major;
					arg_d    = '0;
					argdue_d = 4'(4'd1 << info[1:0]);
				end
			end
			if (hd) begin
				case (hmaj)
					cisv_pkg::MAJ_BSTR, cisv_pkg::MAJ_TSTR: begin
						if (hval == 64'd0) idone = 1'b1;
						else pay_d = hval;
					end
					cisv_pkg::MAJ_ARRAY: begin
						is_cont = 1'b1;
						cnt     = hval;
					end
					cisv_pkg::MAJ_MAP: begin
						// pair count doubles modulo 2^64
						is_cont = 1'b1;
						cnt     = {hval[62:0], 1'b0};
					end
					cisv_pkg::MAJ_TAG: begin
						is_cont = 1'b1;
						cnt     = 64'd1;
					end
					default: idone = 1'b1;
				endcase
				if (is_cont) begin
					if (cnt == 64'd0) begin
						idone = 1'b1;
					end else if (nest_q == NW'(MAX_NEST)) begin
						deep = 1'b1;
					end else begin
						push_we = (nest_q != '0);
						top_d   = cnt;
						nest_d  = nest_q + NW'(1);
					end
				end
			end
			if (idone) begin
				if (nest_q == '0) begin
					done0 = 1'b1;
				end else if (top_q != 64'd1) begin
					top_d = top_q - 64'd1;
				end else begin
					nest_d = nest_q - NW'(1);
					if (nest_q == NW'(1)) done0 = 1'b1;
					else need_pop = 1'b1;
				end
			end
		end
		if (cmd.pop) begin
			// stored counts are never zero
			if (rd_q != 64'd1) begin
				top_d = rd_q - 64'd1;
			end else begin
				nest_d = nest_q - NW'(1);
				if (nest_q == NW'(1)) done0 = 1'b1;
				else need_pop = 1'b1;
			end
		end
	end

	always_comb begin
		vld  = 1'b0;
		code = cisv_pkg::ST_OK;
		if (cmd.emit) begin
			vld  = vval_q;
			code = vcode_q;
		end else if ((cmd.proc && !err_q) || cmd.pop) begin
			if (done0) begin
				vld  = 1'b1;
				code = cisv_pkg::ST_OK;
			end else if (rsvd) begin
				vld  = 1'b1;
				code = cisv_pkg::ST_RSVD;
			end else if (deep) begin
				vld  = 1'b1;
				code = cisv_pkg::ST_DEEP;
			end else if (last_q && !need_pop) begin
				vld  = 1'b1;
				code = cisv_pkg::ST_TRUNC;
			end
		end
	end

	assign start_use     = cmd.proc ? start_d : start_q;
	assign out_free      = !out_valid_q || !result_stall;
	assign buf_end       = cmd.fin && last_q;
	assign stat.need_pop = need_pop;
	assign stat.vld      = vld;
	assign stat.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q    <= 1'b0;
			argdue_q <= '0;
			arg_q    <= '0;
			pmaj_q   <= '0;
			pay_q    <= '0;
			nest_q   <= '0;
			top_q    <= '0;
			off_q    <= '0;
			start_q  <= '0;
			vval_q   <= 1'b0;
			vcode_q  <= cisv_pkg::ST_OK;
		end else begin
			// end of buffer: parse state and offsets start over
			argdue_q <= buf_end ? 4'd0 : argdue_d;
			arg_q    <= buf_end ? 64'd0 : arg_d;
			pmaj_q   <= buf_end ? 3'd0 : pmaj_d;
			pay_q    <= buf_end ? 64'd0 : pay_d;
			nest_q   <= buf_end ? '0 : nest_d;
			top_q    <= top_d;
			start_q  <= buf_end ? 64'd0 : start_d;
			if (cmd.proc || cmd.pop) begin
				vval_q  <= vld;
				vcode_q <= code;
			end
			if (buf_end) begin
				err_q <= 1'b0;
				off_q <= '0;
			end else if (cmd.fin) begin
				off_q <= off_q + 64'd1;
				if (vld && code != cisv_pkg::ST_OK) err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			byte_q <= in_byte;
			last_q <= last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (push_we) mem[waddr] <= top_q;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin && vld) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && vld) begin
			status_q <= code;
			ostart_q <= start_use;
			olen_q   <= off_q - start_use + 64'd1;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign item_start   = ostart_q;
	assign item_length  = olen_q;

`ifndef SYNTH
	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NW'(MAX_NEST))
		else $error("nesting level beyond limit");

	a_arg_pay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(argdue_q != 4'd0 && pay_q != 64'd0))
		else $error("argument and payload bytes due together");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> nest_q != '0)
		else $error("pop with empty stack");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && last_q |=> off_q == 64'd0 && nest_q == '0 && !err_q)
		else $error("state not cleared after last byte");
`endif

endmodule
`default_nettype wire

// ===== src/cbor_item_skip_validator.sv =====
// A byte is latched while idle and decoded in the process state; each nesting level that
// it closes adds a pop state, but for the outermost when it ends a top-level item, as set
// by the one-read child-count stack. The byte's result is registered when the byte is done,
// and no new byte is taken before that. A verdict that finds the result register full waits
// for the sink. Reset: arst_n clears parse state, offsets and the controller; the stack
// memory is not cleared, every entry is written first.
`default_nettype none
module cbor_item_skip_validator #(
	parameter int MAX_NEST = cisv_pkg::MAX_NEST_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         byte_valid,
	output logic        byte_stall,
	input  wire [7:0]   in_byte,
	input  wire         last_byte,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [1:0]  status,
	output logic [63:0] item_start,
	output logic [63:0] item_length
);

	cisv_pkg::cmd_t  cmd;
	cisv_pkg::stat_t stat;

	cisv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	cisv_dp #(
		.MAX_NEST (MAX_NEST)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_byte      (in_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.item_start   (item_start),
		.item_length  (item_length)
	);

endmodule
`default_nettype wire

// ===== bench/tb_cbor_item_skip_validator.sv =====
// Self-checking testbench for the CBOR item skip validator: byte streams in, item extents out.
`timescale 1ns / 1ps
module tb_cbor_item_skip_validator;

	localparam int MAX_NEST = cisv_pkg::MAX_NEST_DEF;
	localparam int RAND_BYTES = 640;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = MAX_NEST + 16;
	localparam int NO_VERDICT = -1;

	// majors the package leaves unnamed
	localparam logic [2:0] MAJ_UINT   = 3'd0;
	localparam logic [2:0] MAJ_NINT   = 3'd1;
	localparam logic [2:0] MAJ_SIMPLE = 3'd7;
	localparam logic [4:0] INFO_RSVD_LO = 5'd28;
	localparam logic [4:0] INFO_RSVD_HI = 5'd31;

	typedef struct {
		logic [1:0]  status;
		logic [63:0] item_start;
		logic [63:0] item_length;
	} extent_t;

	class extent_tracker;
		bit          err_seen;
		logic [3:0]  arg_left;
		logic [63:0] arg_acc;
		logic [2:0]  held_major;
		logic [63:0] payload_left;
		logic [5:0]  depth;
		logic [63:0] child_left [0:MAX_NEST];
		logic [63:0] offset;
		logic [63:0] origin;
		int          verdict;
		extent_t     due_extents[$];
		int          errors;
		int          live_bytes;
		int          status_count[4];

		function new();
			err_seen = 1'b0;
			clear_parse();
			offset = '0;
			origin = '0;
			errors = 0;
			live_bytes = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function void clear_parse();
			arg_left = '0;
			arg_acc = '0;
			held_major = '0;
			payload_left = '0;
			depth = '0;
			foreach (child_left[i]) child_left[i] = '0;
		endfunction

		// a data item ended: pop every level whose children are now all present
		function void close_item();
			int top;
			while (depth > 0) begin
				top = int'(depth) - 1;
				if (top > MAX_NEST) top = MAX_NEST;
				child_left[top] = child_left[top] - 64'd1;
				if (child_left[top] != 0) return;
				depth = 6'(top);
			end
			verdict = cisv_pkg::ST_OK;
		endfunction

		function void finish_head(logic [2:0] maj, logic [63:0] val);
			logic [63:0] cnt;
			case (maj)
				cisv_pkg::MAJ_BSTR, cisv_pkg::MAJ_TSTR: begin
					if (val == 0) close_item();
					else payload_left = val;
					return;
				end
				cisv_pkg::MAJ_ARRAY: cnt = val;
				cisv_pkg::MAJ_MAP:   cnt = val << 1;
				cisv_pkg::MAJ_TAG:   cnt = 64'd1;
				default: begin
					close_item();
					return;
				end
			endcase
			if (cnt == 0) begin
				close_item();
				return;
			end
			if (int'(depth) + 1 > MAX_NEST) begin
				verdict = cisv_pkg::ST_DEEP;
				return;
			end
			child_left[depth] = cnt;
			depth = depth + 6'd1;
		endfunction

		function void parse_byte(logic [7:0] b);
			logic [2:0] maj;
			logic [4:0] info;
			if (arg_left > 0) begin
				arg_acc = {arg_acc[55:0], b};
				arg_left = arg_left - 4'd1;
				if (arg_left == 0) finish_head(held_major, arg_acc);
				return;
			end
			if (payload_left > 0) begin
				payload_left = payload_left - 64'd1;
				if (payload_left == 0) close_item();
				return;
			end
			maj = b[7:5];
			info = b[4:0];
			if (depth == 0) origin = offset;
			if (info < cisv_pkg::INFO_ARG1) finish_head(maj, 64'(info));
			else if (info > cisv_pkg::INFO_ARG8) verdict = cisv_pkg::ST_RSVD;
			else begin
				held_major = maj;
				arg_acc = '0;
				arg_left = 4'(1 << (info - cisv_pkg::INFO_ARG1));
			end
		endfunction

		// one accepted byte transaction
		function void take_byte(logic [7:0] b, logic lst);
			extent_t e;
			verdict = NO_VERDICT;
			if (!err_seen) begin
				live_bytes++;
				parse_byte(b);
				if (verdict == NO_VERDICT && lst) verdict = cisv_pkg::ST_TRUNC;
				if (verdict != NO_VERDICT) begin
					e.status = 2'(verdict);
					e.item_start = origin;
					e.item_length = offset - origin + 64'd1;
					due_extents.push_back(e);
					if (verdict != cisv_pkg::ST_OK) err_seen = 1'b1;
				end
			end
			offset = offset + 64'd1;
			if (lst) begin
				err_seen = 1'b0;
				clear_parse();
				offset = '0;
				origin = '0;
			end
		endfunction

		function void match_result(logic [1:0] st, logic [63:0] s, logic [63:0] l);
			extent_t w;
			if (due_extents.size() == 0) begin
				$display("%0t: unexpected result status %0d start %0d length %0d",
					$time, st, s, l);
				errors++;
				return;
			end
			w = due_extents.pop_front();
			status_count[st]++;
			if (st !== w.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, w.status, st);
				errors++;
			end
			if (s !== w.item_start) begin
				$display("%0t: item_start mismatch, expected %0d, got %0d",
					$time, w.item_start, s);
				errors++;
			end
			if (l !== w.item_length) begin
				$display("%0t: item_length mismatch, expected %0d, got %0d",
					$time, w.item_length, l);
				errors++;
			end
		endfunction

		function void flush_missing();
			extent_t w;
			while (due_extents.size() > 0) begin
				w = due_extents.pop_front();
				$display("%0t: missing result, expected status %0d start %0d length %0d",
					$time, w.status, w.item_start, w.item_length);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  status;
	logic [63:0] item_start;
	logic [63:0] item_length;

	extent_tracker sb = new();
	logic [7:0] stream_q[$];
	int  snd_idle = 0;
	int  rcv_idle = 0;
	bit  hold_req = 1'b0;
	int  buffers = 0;
	int  sent_bytes = 0;

	cbor_item_skip_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.item_start   (item_start),
		.item_length  (item_length)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) sb.take_byte(in_byte, last_byte);
		if (arst_n && result_valid && !result_stall)
			sb.match_result(status, item_start, item_length);
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else
				result_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void push(logic [7:0] b);
		stream_q.push_back(b);
	endfunction

	// form < 0 picks the shortest head, else 0..3 forces 1, 2, 4 or 8 argument bytes
	function automatic void add_head(logic [2:0] maj, logic [63:0] val, int form);
		int f;
		int i;
		f = form;
		if (f < 0) begin
			if (val < 24) begin
				push({maj, val[4:0]});
				return;
			end
			f = (val < 256) ? 0 : (val < 65536) ? 1 : (val < 64'h1_0000_0000) ? 2 : 3;
		end
		push({maj, 5'(cisv_pkg::INFO_ARG1 + f)});
		for (i = (1 << f) - 1; i >= 0; i--) push(val[8*i +: 8]);
	endfunction

	function automatic logic [63:0] rand_arg();
		case ($urandom_range(3))
			0: return 64'($urandom_range(23));
			1: return 64'($urandom_range(255));
			2: return 64'($urandom_range(65535));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly shortest form; sometimes a longer, non-canonical head
	function automatic int pick_form(logic [63:0] v);
		int lo;
		if ($urandom_range(3) != 0) return -1;
		lo = (v < 65536) ? ((v < 256) ? 0 : 1) : ((v < 64'h1_0000_0000) ? 2 : 3);
		return $urandom_range(3, lo);
	endfunction

	function automatic void put_item(int lvl);
		int kind;
		int n;
		logic [63:0] v;
		logic [2:0] maj;
		kind = (lvl >= 4) ? $urandom_range(4) : $urandom_range(7);
		case (kind)
			0, 1, 2, 3: begin
				case ($urandom_range(2))
					0: maj = MAJ_UINT;
					1: maj = MAJ_NINT;
					default: maj = MAJ_SIMPLE;
				endcase
				v = rand_arg();
				add_head(maj, v, pick_form(v));
			end
			4: begin
				n = $urandom_range(5);
				add_head($urandom_range(1) ? cisv_pkg::MAJ_BSTR : cisv_pkg::MAJ_TSTR,
					64'(n), pick_form(64'(n)));
				repeat (n) push(8'($urandom));
			end
			5: begin
				n = $urandom_range(3);
				add_head(cisv_pkg::MAJ_ARRAY, 64'(n), pick_form(64'(n)));
				repeat (n) put_item(lvl + 1);
			end
			6: begin
				n = $urandom_range(2);
				add_head(cisv_pkg::MAJ_MAP, 64'(n), pick_form(64'(n)));
				repeat (2 * n) put_item(lvl + 1);
			end
			default: begin
				v = rand_arg();
				add_head(cisv_pkg::MAJ_TAG, v, pick_form(v));
				put_item(lvl + 1);
			end
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b, logic lst);
		while ($urandom_range(99) < snd_idle) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	task automatic send_queue(bit end_mark);
		int i;
		for (i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], end_mark && (i == stream_q.size() - 1));
		sent_bytes += stream_q.size();
		stream_q.delete();
		buffers++;
	endtask

	task automatic pause_until_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_extents.size() > 0) @(posedge clk);
	endtask

	task automatic run_directed();
		// extremes of the plain integer
		add_head(MAJ_UINT, 64'd0, -1);
		send_queue(1);
		add_head(MAJ_UINT, '1, -1);
		send_queue(1);
		// kinds that close at their head: empty strings and containers, negative, simple; plus a tag on the negative
		add_head(cisv_pkg::MAJ_BSTR, 64'd0, -1);
		add_head(cisv_pkg::MAJ_TSTR, 64'd0, -1);
		add_head(cisv_pkg::MAJ_ARRAY, 64'd0, -1);
		add_head(cisv_pkg::MAJ_MAP, 64'd0, -1);
		add_head(cisv_pkg::MAJ_TAG, 64'd1, -1);
		add_head(MAJ_NINT, 64'd0, -1);
		add_head(MAJ_SIMPLE, 64'd23, -1);
		send_queue(1);
		// map pair count wraps: 2^63 pairs means no children, 2^63+1 means two
		add_head(cisv_pkg::MAJ_MAP, 64'h8000_0000_0000_0000, 3);
		add_head(cisv_pkg::MAJ_MAP, 64'h8000_0000_0000_0001, 3);
		add_head(MAJ_UINT, 64'd1, -1);
		add_head(MAJ_UINT, 64'd2, -1);
		send_queue(1);
		// huge string cut by the buffer end, then a cut inside an argument
		add_head(cisv_pkg::MAJ_BSTR, 64'h8000_0000_0000_0000, 3);
		push(8'hAA);
		push(8'h55);
		send_queue(1);
		push({MAJ_UINT, 5'(cisv_pkg::INFO_ARG1 + 1)});
		push(8'h01);
		send_queue(1);
		// reserved info; the rest of the buffer is ignored
		push({MAJ_UINT, INFO_RSVD_LO});
		push({cisv_pkg::MAJ_BSTR, 5'(INFO_RSVD_LO + 1)});
		push({cisv_pkg::MAJ_ARRAY, 5'(INFO_RSVD_LO + 2)});
		push({MAJ_SIMPLE, INFO_RSVD_HI});
		send_queue(1);
		// reserved info on the marked byte itself
		add_head(MAJ_UINT, 64'd0, -1);
		push({MAJ_NINT, INFO_RSVD_HI});
		send_queue(1);
		// deepest legal nesting closed by one leaf, then an empty array at the limit
		repeat (MAX_NEST) add_head(cisv_pkg::MAJ_ARRAY, 64'd1, -1);
		add_head(MAJ_UINT, 64'd0, -1);
		repeat (MAX_NEST) add_head(cisv_pkg::MAJ_TAG, 64'd0, -1);
		add_head(cisv_pkg::MAJ_ARRAY, 64'd0, -1);
		send_queue(1);
		// one level too deep
		repeat (MAX_NEST + 1) add_head(cisv_pkg::MAJ_ARRAY, 64'd1, -1);
		add_head(MAJ_UINT, 64'd0, -1);
		send_queue(1);
		// offsets run on across an unmarked buffer
		add_head(MAJ_UINT, 64'd1, -1);
		add_head(MAJ_UINT, 64'd2, -1);
		send_queue(0);
		add_head(MAJ_UINT, 64'd3, -1);
		send_queue(1);
	endtask

	task automatic fill_random(int n);
		int base;
		int kind;
		int cut;
		bit end_mark;
		base = sent_bytes;
		while (sent_bytes - base < n) begin
			kind = $urandom_range(99);
			end_mark = 1'b1;
			if (kind < 68) begin
				repeat ($urandom_range(1, 4)) put_item(0);
			end else if (kind < 78) begin
				repeat ($urandom_range(1, 3)) put_item(0);
				cut = $urandom_range(1, stream_q.size());
				stream_q = stream_q[0:cut-1];
			end else if (kind < 86) begin
				repeat ($urandom_range(1, 3)) put_item(0);
				stream_q.insert($urandom_range(stream_q.size()),
					{3'($urandom_range(7)), 5'($urandom_range(INFO_RSVD_HI, INFO_RSVD_LO))});
			end else if (kind < 93) begin
				repeat ($urandom_range(MAX_NEST - 2, MAX_NEST + 2)) begin
					if ($urandom_range(1)) add_head(cisv_pkg::MAJ_ARRAY, 64'd1, -1);
					else add_head(cisv_pkg::MAJ_TAG, rand_arg(), -1);
				end
				put_item(3);
				if ($urandom_range(1)) put_item(0);
			end else begin
				// raw noise, sometimes left open into the next buffer
				repeat ($urandom_range(1, 12)) push(8'($urandom));
				end_mark = $urandom_range(1);
			end
			send_queue(end_mark);
		end
	endtask

	initial begin
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 24;
		rcv_idle = 88;
		run_directed();
		fill_random(RAND_BYTES / 3);

		snd_idle = 88;
		rcv_idle = 24;
		fill_random(RAND_BYTES / 3);

		snd_idle = 0;
		rcv_idle = 0;
		// long sink hold-off while plain integers keep coming: the block backs up
		hold_req = 1'b1;
		repeat (60) add_head(MAJ_UINT, 64'($urandom_range(23)), -1);
		send_queue(1);
		pause_until_drained();
		fill_random(RAND_BYTES / 3 - 60);

		byte_valid <= 1'b0;
		waited = 0;
		while (sb.due_extents.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.flush_missing();

		$display("Sent %0d bytes (%0d parsed) in %0d buffers: well-formed, cut, reserved,",
			sent_bytes, sb.live_bytes, buffers);
		$display("over-deep and noise streams; extents %0d ok, %0d cut, %0d reserved, %0d deep.",
			sb.status_count[cisv_pkg::ST_OK], sb.status_count[cisv_pkg::ST_TRUNC],
			sb.status_count[cisv_pkg::ST_RSVD], sb.status_count[cisv_pkg::ST_DEEP]);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
